/* design/qvr_pkg.sv */
// Shared widths, codes, types and helpers of the quaternion vector rotation unit.
package qvr_pkg;

  // Field widths.
  localparam int VEC_W  = 32;           // Q16.16 vector component
  localparam int Q_W    = 16;           // Q1.14 quaternion component
  localparam int QA_W   = Q_W + 1;      // negated quaternion component (-(-2.0) = +2.0)
  localparam int RND    = 14;           // fraction bits dropped after each product

  // First Hamilton product: 17 x 32 bit terms, three-term sums, rounded.
  localparam int P1_W   = QA_W + VEC_W;
  localparam int S1_W   = P1_W + 2;
  localparam int T_W    = S1_W - RND;

  // Second Hamilton product: T_W x 17 bit terms, four-term sums, rounded.
  localparam int P2_W   = T_W + QA_W;
  localparam int S2_W   = P2_W + 2;
  localparam int R_W    = S2_W - RND;

  localparam int RND_HALF = 2 ** (RND - 1);

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(2 ** RND);

  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_QW = 2'd0,
    REG_QX = 2'd1,
    REG_QY = 2'd2,
    REG_QZ = 2'd3
  } qvr_reg_t;

  typedef enum logic {
    OP_ROTATE  = 1'b0,
    OP_INVERSE = 1'b1
  } qvr_op_t;

  typedef struct packed {
    logic signed [Q_W-1:0] w;
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
  } qvr_quat_t;

  // Intermediate quaternion t = q * p, carried between the two product halves.
  typedef struct packed {
    qvr_op_t               op;
    logic signed [T_W-1:0] w;
    logic signed [T_W-1:0] x;
    logic signed [T_W-1:0] y;
    logic signed [T_W-1:0] z;
  } qvr_tvec_t;

  // Sign-extends a quaternion component and negates it on request, one bit wider
  // so that the most negative code turns into its exact positive value.
  function automatic logic signed [QA_W-1:0] qvr_cond_neg(input logic signed [Q_W-1:0] a,
                                                         input logic neg);
    logic signed [QA_W-1:0] e;
    e = QA_W'(a);
    return neg ? -e : e;
  endfunction

endpackage

/* design/qvr_first_prod.sv */
// First Hamilton product t = q * (0, v): a multiply stage and a sum-and-round stage.
module qvr_first_prod (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  qvr_pkg::qvr_op_t                     in_op,
  input  logic signed [qvr_pkg::VEC_W-1:0]     in_x,
  input  logic signed [qvr_pkg::VEC_W-1:0]     in_y,
  input  logic signed [qvr_pkg::VEC_W-1:0]     in_z,
  input  qvr_pkg::qvr_quat_t                   quat,
  output logic                                 t_valid,
  input  logic                                 t_stall,
  output qvr_pkg::qvr_tvec_t                   t
);

  localparam int P1_W = qvr_pkg::P1_W;
  localparam int S1_W = qvr_pkg::S1_W;
  localparam int T_W  = qvr_pkg::T_W;

  logic signed [qvr_pkg::QA_W-1:0] ax, ay, az;

  // Stage 1 product registers.
  logic                   v1_r;
  qvr_pkg::qvr_op_t       op1_r;
  logic signed [P1_W-1:0] p_wx_r, p_wy_r, p_wz_r;
  logic signed [P1_W-1:0] p_xx_r, p_yy_r, p_zz_r;
  logic signed [P1_W-1:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;

  logic signed [P1_W-1:0] p_wx_nxt, p_wy_nxt, p_wz_nxt;
  logic signed [P1_W-1:0] p_xx_nxt, p_yy_nxt, p_zz_nxt;
  logic signed [P1_W-1:0] p_yz_nxt, p_zy_nxt, p_zx_nxt, p_xz_nxt, p_xy_nxt, p_yx_nxt;

  // Stage 2 result registers.
  logic                   v2_r;
  qvr_pkg::qvr_tvec_t     t_r;
  qvr_pkg::qvr_tvec_t     t_nxt;

  logic signed [S1_W-1:0] sw, sx, sy, sz;
  logic                   en1, en2;

  // A stage loads when it is empty or when the stage after it moves.
  assign en2      = !v2_r || !t_stall;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  assign ax = qvr_pkg::qvr_cond_neg(quat.x, in_op == qvr_pkg::OP_INVERSE);
  assign ay = qvr_pkg::qvr_cond_neg(quat.y, in_op == qvr_pkg::OP_INVERSE);
  assign az = qvr_pkg::qvr_cond_neg(quat.z, in_op == qvr_pkg::OP_INVERSE);

  always_comb begin
    p_wx_nxt = P1_W'(quat.w) * P1_W'(in_x);
    p_wy_nxt = P1_W'(quat.w) * P1_W'(in_y);
    p_wz_nxt = P1_W'(quat.w) * P1_W'(in_z);
    p_xx_nxt = P1_W'(ax) * P1_W'(in_x);
    p_yy_nxt = P1_W'(ay) * P1_W'(in_y);
    p_zz_nxt = P1_W'(az) * P1_W'(in_z);
    p_yz_nxt = P1_W'(ay) * P1_W'(in_z);
    p_zy_nxt = P1_W'(az) * P1_W'(in_y);
    p_zx_nxt = P1_W'(az) * P1_W'(in_x);
    p_xz_nxt = P1_W'(ax) * P1_W'(in_z);
    p_xy_nxt = P1_W'(ax) * P1_W'(in_y);
    p_yx_nxt = P1_W'(ay) * P1_W'(in_x);
  end

  always_comb begin
    sw = -(S1_W'(p_xx_r) + S1_W'(p_yy_r) + S1_W'(p_zz_r));
    sx = S1_W'(p_wx_r) + (S1_W'(p_yz_r) - S1_W'(p_zy_r));
    sy = S1_W'(p_wy_r) + (S1_W'(p_zx_r) - S1_W'(p_xz_r));
    sz = S1_W'(p_wz_r) + (S1_W'(p_xy_r) - S1_W'(p_yx_r));

    // Round half up: add one half, then an arithmetic shift.
    t_nxt.op = op1_r;
    t_nxt.w  = T_W'((sw + S1_W'(qvr_pkg::RND_HALF)) >>> qvr_pkg::RND);
    t_nxt.x  = T_W'((sx + S1_W'(qvr_pkg::RND_HALF)) >>> qvr_pkg::RND);
    t_nxt.y  = T_W'((sy + S1_W'(qvr_pkg::RND_HALF)) >>> qvr_pkg::RND);
    t_nxt.z  = T_W'((sz + S1_W'(qvr_pkg::RND_HALF)) >>> qvr_pkg::RND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r  <= in_op;
      p_wx_r <= p_wx_nxt;
      p_wy_r <= p_wy_nxt;
      p_wz_r <= p_wz_nxt;
      p_xx_r <= p_xx_nxt;
      p_yy_r <= p_yy_nxt;
      p_zz_r <= p_zz_nxt;
      p_yz_r <= p_yz_nxt;
      p_zy_r <= p_zy_nxt;
      p_zx_r <= p_zx_nxt;
      p_xz_r <= p_xz_nxt;
      p_xy_r <= p_xy_nxt;
      p_yx_r <= p_yx_nxt;
    end
    if (en2) begin
      t_r <= t_nxt;
    end
  end

  assign t_valid = v2_r;
  assign t       = t_r;

endmodule

/* design/qvr_second_prod.sv */
// Second Hamilton product r = t * conj(q): a multiply stage and a sum, round and clip stage.
module qvr_second_prod (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 t_valid,
  output logic                                 t_stall,
  input  qvr_pkg::qvr_tvec_t                   t,
  input  qvr_pkg::qvr_quat_t                   quat,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qvr_pkg::VEC_W-1:0]     out_x,
  output logic signed [qvr_pkg::VEC_W-1:0]     out_y,
  output logic signed [qvr_pkg::VEC_W-1:0]     out_z,
  output logic                                 out_saturated
);

  localparam int VEC_W = qvr_pkg::VEC_W;
  localparam int P2_W  = qvr_pkg::P2_W;
  localparam int S2_W  = qvr_pkg::S2_W;
  localparam int R_W   = qvr_pkg::R_W;

  logic signed [qvr_pkg::QA_W-1:0] cx, cy, cz;
  logic                            cneg;

  // Stage 3 product registers.
  logic                   v3_r;
  logic signed [P2_W-1:0] p_wcx_r, p_wcy_r, p_wcz_r;   // tw * c
  logic signed [P2_W-1:0] p_qx_r, p_qy_r, p_qz_r;      // w * t
  logic signed [P2_W-1:0] p_ycz_r, p_zcy_r, p_zcx_r, p_xcz_r, p_xcy_r, p_ycx_r;

  logic signed [P2_W-1:0] p_wcx_nxt, p_wcy_nxt, p_wcz_nxt;
  logic signed [P2_W-1:0] p_qx_nxt, p_qy_nxt, p_qz_nxt;
  logic signed [P2_W-1:0] p_ycz_nxt, p_zcy_nxt, p_zcx_nxt, p_xcz_nxt, p_xcy_nxt, p_ycx_nxt;

  // Stage 4 output registers.
  logic                    v4_r;
  logic signed [VEC_W-1:0] ox_r, oy_r, oz_r;
  logic signed [VEC_W-1:0] ox_nxt, oy_nxt, oz_nxt;
  logic                    sat_r, sat_nxt;

  logic signed [S2_W-1:0]  sx, sy, sz;
  logic signed [R_W-1:0]   rx, ry, rz;
  logic                    satx, saty, satz;
  logic                    en3, en4;

  // Clips a rounded component to the output range; the top bit flags a clip.
  function automatic logic [VEC_W:0] clip(input logic signed [R_W-1:0] r);
    logic hi_ones, hi_zeros;
    hi_ones  = &r[R_W-1:VEC_W-1];
    hi_zeros = ~|r[R_W-1:VEC_W-1];
    if (hi_ones || hi_zeros) begin
      return {1'b0, r[VEC_W-1:0]};
    end else if (r[R_W-1]) begin
      return {1'b1, qvr_pkg::VEC_MIN};
    end else begin
      return {1'b1, qvr_pkg::VEC_MAX};
    end
  endfunction

  assign en4     = !v4_r || !out_stall;
  assign en3     = !v3_r || en4;
  assign t_stall = !en3;

  // c is the vector part of the conjugate of the effective quaternion.
  assign cneg = (t.op == qvr_pkg::OP_ROTATE);
  assign cx   = qvr_pkg::qvr_cond_neg(quat.x, cneg);
  assign cy   = qvr_pkg::qvr_cond_neg(quat.y, cneg);
  assign cz   = qvr_pkg::qvr_cond_neg(quat.z, cneg);

  always_comb begin
    p_wcx_nxt = P2_W'(t.w) * P2_W'(cx);
    p_wcy_nxt = P2_W'(t.w) * P2_W'(cy);
    p_wcz_nxt = P2_W'(t.w) * P2_W'(cz);
    p_qx_nxt  = P2_W'(quat.w) * P2_W'(t.x);
    p_qy_nxt  = P2_W'(quat.w) * P2_W'(t.y);
    p_qz_nxt  = P2_W'(quat.w) * P2_W'(t.z);
    p_ycz_nxt = P2_W'(t.y) * P2_W'(cz);
    p_zcy_nxt = P2_W'(t.z) * P2_W'(cy);
    p_zcx_nxt = P2_W'(t.z) * P2_W'(cx);
    p_xcz_nxt = P2_W'(t.x) * P2_W'(cz);
    p_xcy_nxt = P2_W'(t.x) * P2_W'(cy);
    p_ycx_nxt = P2_W'(t.y) * P2_W'(cx);
  end

  always_comb begin
    sx = S2_W'(p_wcx_r) + S2_W'(p_qx_r) + (S2_W'(p_ycz_r) - S2_W'(p_zcy_r));
    sy = S2_W'(p_wcy_r) + S2_W'(p_qy_r) + (S2_W'(p_zcx_r) - S2_W'(p_xcz_r));
    sz = S2_W'(p_wcz_r) + S2_W'(p_qz_r) + (S2_W'(p_xcy_r) - S2_W'(p_ycx_r));

    rx = R_W'((sx + S2_W'(qvr_pkg::RND_HALF)) >>> qvr_pkg::RND);
    ry = R_W'((sy + S2_W'(qvr_pkg::RND_HALF)) >>> qvr_pkg::RND);
    rz = R_W'((sz + S2_W'(qvr_pkg::RND_HALF)) >>> qvr_pkg::RND);

    {satx, ox_nxt} = clip(rx);
    {saty, oy_nxt} = clip(ry);
    {satz, oz_nxt} = clip(rz);
    sat_nxt = satx || saty || satz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) begin
        v3_r <= t_valid;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      p_wcx_r <= p_wcx_nxt;
      p_wcy_r <= p_wcy_nxt;
      p_wcz_r <= p_wcz_nxt;
      p_qx_r  <= p_qx_nxt;
      p_qy_r  <= p_qy_nxt;
      p_qz_r  <= p_qz_nxt;
      p_ycz_r <= p_ycz_nxt;
      p_zcy_r <= p_zcy_nxt;
      p_zcx_r <= p_zcx_nxt;
      p_xcz_r <= p_xcz_nxt;
      p_xcy_r <= p_xcy_nxt;
      p_ycx_r <= p_ycx_nxt;
    end
    if (en4) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      oz_r  <= oz_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = v4_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_saturated = sat_r;

endmodule

/* design/quaternion_vector_rotate_unit.sv */
// Pipeline: an accepted item reaches the outputs through four register stages, two per
// Hamilton product (stages 1 and 2 in the first, stages 3 and 4 in the second).
// Throughput: one item per cycle; every stage loads when it is empty or its successor
// moves, so bubbles close up, and a stalled output holds off the input only once all
// four stages hold an item.
// Reset: synchronous, active low; it empties the pipeline and loads the identity
// rotation (w = 1.0, x = y = z = 0) into the quaternion registers.
module quaternion_vector_rotate_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input items.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_opcode,
  input  logic signed [qvr_pkg::VEC_W-1:0]      in_vec_x,
  input  logic signed [qvr_pkg::VEC_W-1:0]      in_vec_y,
  input  logic signed [qvr_pkg::VEC_W-1:0]      in_vec_z,
  // Result items.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [qvr_pkg::VEC_W-1:0]      out_x,
  output logic signed [qvr_pkg::VEC_W-1:0]      out_y,
  output logic signed [qvr_pkg::VEC_W-1:0]      out_z,
  output logic                                  out_saturated,
  // Configuration port.
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [qvr_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [qvr_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [qvr_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);

  // The rotation quaternion. Software must write it only while the pipeline is empty;
  // the block does not enforce this. Both product halves read it directly, carrying no copy.
  qvr_pkg::qvr_quat_t  quat_r;
  qvr_pkg::qvr_quat_t  quat_nxt;
  qvr_pkg::qvr_reg_t   cfg_sel;
  qvr_pkg::qvr_tvec_t  t;
  logic                cfg_wr;
  logic                t_valid;
  logic                t_stall;
  logic [qvr_pkg::Q_W-1:0] rd_val;

  // Registers sit on word addresses; the two low address bits are not decoded.
  assign cfg_sel    = qvr_pkg::qvr_reg_t'(cfg_paddr[qvr_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    quat_nxt = quat_r;
    if (cfg_wr) begin
      case (cfg_sel)
        qvr_pkg::REG_QW: quat_nxt.w = cfg_pwdata[qvr_pkg::Q_W-1:0];
        qvr_pkg::REG_QX: quat_nxt.x = cfg_pwdata[qvr_pkg::Q_W-1:0];
        qvr_pkg::REG_QY: quat_nxt.y = cfg_pwdata[qvr_pkg::Q_W-1:0];
        qvr_pkg::REG_QZ: quat_nxt.z = cfg_pwdata[qvr_pkg::Q_W-1:0];
        default:         quat_nxt   = quat_r;
      endcase
    end
  end

  // Reads return the stored component sign-extended to the bus width.
  always_comb begin
    case (cfg_sel)
      qvr_pkg::REG_QW: rd_val = quat_r.w;
      qvr_pkg::REG_QX: rd_val = quat_r.x;
      qvr_pkg::REG_QY: rd_val = quat_r.y;
      qvr_pkg::REG_QZ: rd_val = quat_r.z;
      default:         rd_val = '0;
    endcase
  end

  assign cfg_prdata = qvr_pkg::CFG_DATA_W'($signed(rd_val));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r.w <= qvr_pkg::Q_ONE;
      quat_r.x <= '0;
      quat_r.y <= '0;
      quat_r.z <= '0;
    end else begin
      quat_r <= quat_nxt;
    end
  end

  // First half: t = q * (0, v), with q conjugated for the inverse rotation.
  qvr_first_prod u_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (qvr_pkg::qvr_op_t'(in_opcode)),
    .in_x     (in_vec_x),
    .in_y     (in_vec_y),
    .in_z     (in_vec_z),
    .quat     (quat_r),
    .t_valid  (t_valid),
    .t_stall  (t_stall),
    .t        (t)
  );

  // Second half: vector part of t * conj(q), rounded and saturated.
  qvr_second_prod u_second (
    .clk           (clk),
    .rst_n         (rst_n),
    .t_valid       (t_valid),
    .t_stall       (t_stall),
    .t             (t),
    .quat          (quat_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated)
  );

endmodule

/* design/qvr_checker.sv */
// Port-level checks for the quaternion vector rotation unit, bound to its top level.
module qvr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [qvr_pkg::VEC_W-1:0]  out_x,
  input logic signed [qvr_pkg::VEC_W-1:0]  out_y,
  input logic signed [qvr_pkg::VEC_W-1:0]  out_z,
  input logic                              out_saturated
);

  // A reset cycle leaves no item at the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // The input can only be held off when the pipeline is backed up to a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output is free");

  // A clip flag means at least one component sits on a range bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_x == qvr_pkg::VEC_MAX || out_x == qvr_pkg::VEC_MIN ||
       out_y == qvr_pkg::VEC_MAX || out_y == qvr_pkg::VEC_MIN ||
       out_z == qvr_pkg::VEC_MAX || out_z == qvr_pkg::VEC_MIN))
    else $error("saturation flagged with no component at a bound");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) &&
       $stable(out_saturated)))
    else $error("stalled result changed");

endmodule

bind quaternion_vector_rotate_unit qvr_checker u_qvr_checker (.*);
